### sv/shar_pkg.sv
// Shared types and constants for the SCSI host adapter register block.
// Used by shar_core and scsi_host_adapter_regs_top; depends on nothing.
`timescale 1ns / 1ps

package shar_pkg;

  // Default size of the host-side block buffer in bytes.
  localparam int BUFFER_BYTES_DEF = 128;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_DMA_BEAT = 2'd2,
    OP_POLL_END = 2'd3
  } op_t;

  // DMA modes.
  typedef enum logic [1:0] {
    XFER_IDLE    = 2'd0,
    XFER_SEND    = 2'd1,
    XFER_TRECV   = 2'd2,
    XFER_IRECV   = 2'd3
  } dma_kind_t;

  // Window map.
  localparam logic [13:0] CHIP_BASE = 14'h3880;
  localparam logic [13:0] BUF_BASE  = 14'h3900;
  localparam logic [13:0] CTRL_ADDR = 14'h3980;
  localparam logic [13:0] BLK_ADDR  = 14'h3981;
  localparam logic [13:0] WIN_END   = 14'h3A00;

  // Controller register numbers.
  localparam logic [2:0] REG_DATA       = 3'd0;
  localparam logic [2:0] REG_INIT_CMD   = 3'd1;
  localparam logic [2:0] REG_MODE       = 3'd2;
  localparam logic [2:0] REG_TARGET_CMD = 3'd3;
  localparam logic [2:0] REG_BUS_STATUS = 3'd4;
  localparam logic [2:0] REG_BUS_AND_ST = 3'd5;
  localparam logic [2:0] REG_IN_DATA    = 3'd6;
  localparam logic [2:0] REG_RESET_INT  = 3'd7;

  // Control register masks and reset value.
  localparam logic [7:0] CTL_KEEP_MASK = 8'h87;
  localparam logic [7:0] CTL_HOST_MASK = 8'h78;
  localparam logic [7:0] CTL_RESET     = 8'h04;
  localparam logic [7:0] READ_FILL     = 8'hFF;

  // One request as accepted from the input channel.
  typedef struct packed {
    op_t         op;
    logic [13:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  bus_data;
    logic        bus_req;
    logic        bus_ack;
    logic        bus_bsy;
    logic        bus_io;
    logic        bus_cd;
    logic        bus_msg;
    logic        bus_sel;
    logic        phase_match;
  } item_t;

  // Result of one request, before the buffer read data is merged in.
  typedef struct packed {
    logic [7:0] rdata;
    logic       rdata_from_ram;
    logic [9:0] drive_lines;
    logic [7:0] drive_data;
    logic       data_from_ram;
    logic       ack_pulse;
    logic       dma_active;
  } result_t;

endpackage

### sv/shar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the block buffer; no dependencies.
`timescale 1ns / 1ps

module shar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/shar_core.sv
// Controller and buffer-control registers with the per-request update logic.
// Depends on shar_pkg; drives the ports of the block buffer RAM.
`timescale 1ns / 1ps

module shar_core #(
  parameter int BUFFER_BYTES = shar_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  shar_pkg::item_t                 item,
  output shar_pkg::result_t               result,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int HW = $clog2(BUFFER_BYTES + 1);
  localparam logic [HW-1:0] HOST_END = HW'(BUFFER_BYTES);
  localparam logic [AW-1:0] DMA_LAST = AW'(BUFFER_BYTES - 1);

  logic [7:0]          init_cmd, init_cmd_next;
  logic [7:0]          mode_reg, mode_reg_next;
  logic [7:0]          target_cmd, target_cmd_next;
  logic [7:0]          int_status, int_status_next;
  logic [7:0]          out_byte, out_byte_next;
  shar_pkg::dma_kind_t dma_kind, dma_kind_next;
  logic [7:0]          ctrl_status, ctrl_status_next;
  logic [AW-1:0]       dma_ptr, dma_ptr_next;
  logic [HW-1:0]       host_ptr, host_ptr_next;
  logic [7:0]          blocks_left, blocks_left_next;
  logic                blocks_loaded, blocks_loaded_next;
  logic                chip_busy, chip_busy_next;

  // Request decode and next-state logic. Select enable affects no output and
  // is not stored.
  always_comb begin
    logic [7:0]    rd;
    logic          rd_ram;
    logic          dd_ram;
    logic          ack;
    logic          do_wrap;
    logic          sending;
    logic [7:0]    blk_dec;
    logic [2:0]    ph;
    logic [HW-1:0] host_inc;
    logic [7:0]    ctl_tmp;

    init_cmd_next      = init_cmd;
    mode_reg_next      = mode_reg;
    target_cmd_next    = target_cmd;
    int_status_next    = int_status;
    out_byte_next      = out_byte;
    dma_kind_next      = dma_kind;
    ctrl_status_next   = ctrl_status;
    dma_ptr_next       = dma_ptr;
    host_ptr_next      = host_ptr;
    blocks_left_next   = blocks_left;
    blocks_loaded_next = blocks_loaded;
    chip_busy_next     = chip_busy;
    rd        = 8'h00;
    rd_ram    = 1'b0;
    dd_ram    = 1'b0;
    ack       = 1'b0;
    do_wrap   = 1'b0;
    sending   = 1'b0;
    blk_dec   = blocks_left - 8'd1;
    ph        = {item.bus_msg, item.bus_cd, item.bus_io};
    host_inc  = host_ptr + 1'b1;
    ctl_tmp   = ctrl_status;
    ram_we    = 1'b0;
    ram_waddr = dma_ptr;
    ram_wdata = item.bus_data;
    ram_re    = 1'b0;
    ram_raddr = dma_ptr;

    if (go) begin
      unique case (item.op)
        shar_pkg::OP_READ: begin
          rd = shar_pkg::READ_FILL;
          if (item.addr >= shar_pkg::CHIP_BASE && item.addr < shar_pkg::BUF_BASE) begin
            unique case (item.addr[2:0])
              shar_pkg::REG_DATA:       rd = init_cmd[0] ? out_byte : item.bus_data;
              shar_pkg::REG_INIT_CMD:   rd = init_cmd;
              shar_pkg::REG_MODE:       rd = mode_reg;
              shar_pkg::REG_TARGET_CMD: rd = target_cmd;
              shar_pkg::REG_BUS_STATUS: begin
                rd = {1'b0, item.bus_bsy, item.bus_req, item.bus_msg, item.bus_cd,
                      item.bus_io, item.bus_sel, 1'b0};
              end
              shar_pkg::REG_BUS_AND_ST: begin
                // A DMA request with a phase mismatch raises the interrupt.
                rd = {4'b0000, item.phase_match, 2'b00, item.bus_ack};
                if (item.bus_req && mode_reg[1]) begin
                  rd[6] = 1'b1;
                  if (target_cmd[2:0] != ph) begin
                    int_status_next[4] = 1'b1;
                  end
                end
                if (!item.bus_bsy && mode_reg[2]) begin
                  rd[2] = 1'b1;
                end
                rd = rd | (int_status_next & 8'h90);
              end
              shar_pkg::REG_IN_DATA:    rd = shar_pkg::READ_FILL;
              shar_pkg::REG_RESET_INT:  int_status_next[4] = 1'b0;
              default:                  rd = shar_pkg::READ_FILL;
            endcase
          end else if (item.addr >= shar_pkg::BUF_BASE && item.addr < shar_pkg::CTRL_ADDR) begin
            // Host reads from the buffer while the direction is inbound.
            if (host_ptr < HOST_END && ctrl_status[6]) begin
              ram_re        = 1'b1;
              ram_raddr     = host_ptr[AW-1:0];
              rd_ram        = 1'b1;
              host_ptr_next = host_inc;
              if (host_inc == HOST_END) begin
                ctrl_status_next[2] = 1'b1;
              end
            end
          end else if (item.addr == shar_pkg::CTRL_ADDR) begin
            rd = ctrl_status | (chip_busy ? 8'h00 : 8'h80);
          end else if (item.addr == shar_pkg::BLK_ADDR) begin
            rd = blocks_left;
          end
        end

        shar_pkg::OP_WRITE: begin
          if (item.addr >= shar_pkg::CHIP_BASE && item.addr < shar_pkg::BUF_BASE) begin
            unique case (item.addr[2:0])
              shar_pkg::REG_DATA:       out_byte_next = item.wdata;
              shar_pkg::REG_INIT_CMD:   init_cmd_next = item.wdata;
              shar_pkg::REG_MODE: begin
                if (item.wdata[0] && !mode_reg[0]) begin
                  init_cmd_next[5] = 1'b0;
                  init_cmd_next[6] = 1'b1;
                end
                mode_reg_next = item.wdata;
                // Writing the mode with DMA off clears end-of-DMA and drops to idle.
                if (!item.wdata[1]) begin
                  target_cmd_next[7] = 1'b0;
                  int_status_next[7] = 1'b0;
                  dma_kind_next      = shar_pkg::XFER_IDLE;
                end
              end
              shar_pkg::REG_TARGET_CMD: target_cmd_next = item.wdata;
              shar_pkg::REG_BUS_STATUS: ;
              shar_pkg::REG_BUS_AND_ST: dma_kind_next = shar_pkg::XFER_SEND;
              shar_pkg::REG_IN_DATA:    ;
              shar_pkg::REG_RESET_INT:  dma_kind_next = shar_pkg::XFER_IRECV;
              default:                  ;
            endcase
          end else if (item.addr >= shar_pkg::BUF_BASE && item.addr < shar_pkg::CTRL_ADDR) begin
            // Host fills the buffer while the direction is outbound.
            if (!ctrl_status[6] && host_ptr < HOST_END) begin
              ram_we        = 1'b1;
              ram_waddr     = host_ptr[AW-1:0];
              ram_wdata     = item.wdata;
              host_ptr_next = host_inc;
              if (host_inc == HOST_END) begin
                ctrl_status_next[2] = 1'b1;
                chip_busy_next      = 1'b1;
              end
            end
          end else if (item.addr == shar_pkg::CTRL_ADDR) begin
            // A change of direction resets the host pointer.
            if (item.wdata[6] && !ctrl_status[6]) begin
              host_ptr_next = HOST_END;
              ctl_tmp[2]    = 1'b1;
            end else if (!item.wdata[6] && ctrl_status[6]) begin
              host_ptr_next = '0;
              ctl_tmp[2]    = 1'b0;
            end
            ctrl_status_next = (ctl_tmp & shar_pkg::CTL_KEEP_MASK)
                             | (item.wdata & shar_pkg::CTL_HOST_MASK);
          end else if (item.addr == shar_pkg::BLK_ADDR) begin
            blocks_left_next   = item.wdata;
            blocks_loaded_next = 1'b1;
            if (ctrl_status[6]) begin
              host_ptr_next       = HOST_END;
              ctrl_status_next[2] = 1'b1;
            end else begin
              host_ptr_next       = '0;
              ctrl_status_next[2] = 1'b0;
            end
          end
        end

        shar_pkg::OP_DMA_BEAT: begin
          // A beat moves one byte only when DMA is active and the buffer is ours.
          if (dma_kind != shar_pkg::XFER_IDLE && mode_reg[1] && blocks_loaded
              && item.bus_req && ctrl_status[2]) begin
            if (dma_kind == shar_pkg::XFER_SEND && !ctrl_status[6]) begin
              ram_re    = 1'b1;
              ram_raddr = dma_ptr;
              dd_ram    = 1'b1;
              ack       = 1'b1;
              sending   = 1'b1;
              do_wrap   = (dma_ptr == DMA_LAST);
              dma_ptr_next = dma_ptr + 1'b1;
            end else if (dma_kind == shar_pkg::XFER_IRECV && ctrl_status[6]) begin
              ram_we    = 1'b1;
              ram_waddr = dma_ptr;
              ram_wdata = item.bus_data;
              ack       = 1'b1;
              do_wrap   = (dma_ptr == DMA_LAST);
              dma_ptr_next = dma_ptr + 1'b1;
            end
          end
        end

        shar_pkg::OP_POLL_END: begin
          // Busy monitoring: BSY low ends DMA.
          if (!item.bus_bsy && mode_reg[2]) begin
            mode_reg_next[1] = 1'b0;
            dma_kind_next    = shar_pkg::XFER_IDLE;
          end
        end

        default: ;
      endcase
    end

    // Buffer wrap: hand the buffer back and count down one block.
    if (do_wrap) begin
      dma_ptr_next        = '0;
      host_ptr_next       = '0;
      ctrl_status_next[2] = 1'b0;
      blocks_left_next    = blk_dec;
      if (sending) begin
        chip_busy_next = 1'b0;
      end
      if (blk_dec == 8'd0) begin
        blocks_loaded_next = 1'b0;
        if (sending) begin
          target_cmd_next[7] = 1'b1;
        end
        int_status_next[7] = 1'b1;
        if (mode_reg[3]) begin
          int_status_next[4] = 1'b1;
        end
      end
    end

    result.rdata          = rd;
    result.rdata_from_ram = rd_ram;
    result.drive_lines    = {mode_reg_next[0], init_cmd_next[4], init_cmd_next[3],
                             target_cmd_next[3], target_cmd_next[2], target_cmd_next[1],
                             target_cmd_next[0], init_cmd_next[1], init_cmd_next[2],
                             init_cmd_next[0]};
    result.drive_data     = out_byte_next;
    result.data_from_ram  = dd_ram;
    result.ack_pulse      = ack;
    result.dma_active     = (dma_kind_next != shar_pkg::XFER_IDLE) && mode_reg_next[1]
                            && blocks_loaded_next;
  end

  // State registers, updated once per processed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cmd      <= 8'h00;
      mode_reg      <= 8'h00;
      target_cmd    <= 8'h00;
      int_status    <= 8'h00;
      out_byte      <= 8'h00;
      dma_kind      <= shar_pkg::XFER_IDLE;
      ctrl_status   <= shar_pkg::CTL_RESET;
      dma_ptr       <= '0;
      host_ptr      <= HOST_END;
      blocks_left   <= 8'h00;
      blocks_loaded <= 1'b0;
      chip_busy     <= 1'b0;
    end else if (go) begin
      init_cmd      <= init_cmd_next;
      mode_reg      <= mode_reg_next;
      target_cmd    <= target_cmd_next;
      int_status    <= int_status_next;
      out_byte      <= out_byte_next;
      dma_kind      <= dma_kind_next;
      ctrl_status   <= ctrl_status_next;
      dma_ptr       <= dma_ptr_next;
      host_ptr      <= host_ptr_next;
      blocks_left   <= blocks_left_next;
      blocks_loaded <= blocks_loaded_next;
      chip_busy     <= chip_busy_next;
    end
  end

endmodule

### sv/scsi_host_adapter_regs_top.sv
// SCSI host adapter register block: top level with input and result registers.
// Depends on shar_pkg, shar_core and shar_ram.
`timescale 1ns / 1ps

// One request per clock is taken in every cycle in which the result side
// moves. A request accepted into the input register is processed from there
// once the result side moves, and its result is written to the result
// register at the edge at which it moves on; buffer data read by that request
// arrives from the block buffer RAM's registered read port at that same edge.
// A result stalled at the output holds the pipeline; the input register then
// holds one more request and the input stalls.
// There is no startup sweep: the block buffer is written before it is read.
module scsi_host_adapter_regs_top #(
  parameter int BUFFER_BYTES = shar_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [13:0] addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  bus_data,
  input  logic        bus_req,
  input  logic        bus_ack,
  input  logic        bus_bsy,
  input  logic        bus_io,
  input  logic        bus_cd,
  input  logic        bus_msg,
  input  logic        bus_sel,
  input  logic        phase_match,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  rdata,
  output logic [9:0]  drive_lines,
  output logic [7:0]  drive_data,
  output logic        ack_pulse,
  output logic        dma_active
);

  localparam int AW = $clog2(BUFFER_BYTES);

  shar_pkg::item_t   item_a;
  logic              valid_a;
  logic              advance;
  shar_pkg::result_t res_comb;
  shar_pkg::result_t res_b;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_q;

  // The staged request moves on when the result register is free or draining.
  assign advance  = valid_a && (!out_valid || !out_stall);
  assign in_stall = valid_a && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (!in_stall) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_a.op          <= shar_pkg::op_t'(op);
      item_a.addr        <= addr;
      item_a.wdata       <= wdata;
      item_a.bus_data    <= bus_data;
      item_a.bus_req     <= bus_req;
      item_a.bus_ack     <= bus_ack;
      item_a.bus_bsy     <= bus_bsy;
      item_a.bus_io      <= bus_io;
      item_a.bus_cd      <= bus_cd;
      item_a.bus_msg     <= bus_msg;
      item_a.bus_sel     <= bus_sel;
      item_a.phase_match <= phase_match;
    end
  end

  shar_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (advance),
    .item     (item_a),
    .result   (res_comb),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr)
  );

  shar_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buffer (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_b <= res_comb;
    end
  end

  // Buffer read data joins the result here.
  assign rdata       = res_b.rdata_from_ram ? ram_q : res_b.rdata;
  assign drive_lines = res_b.drive_lines;
  assign drive_data  = res_b.data_from_ram ? ram_q : res_b.drive_data;
  assign ack_pulse   = res_b.ack_pulse;
  assign dma_active  = res_b.dma_active;

endmodule
